@@ design/rppa_pkg.sv @@
`default_nettype none
package rppa_pkg;

  localparam int PAGE_SHIFT = 12;
  localparam int PN_W       = 20;
  localparam int DUMP_MAX   = 64;

  localparam logic [1:0] KIND_FREE  = 2'd0;
  localparam logic [1:0] KIND_ALLOC = 2'd1;
  localparam logic [1:0] KIND_DUMP  = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_FREE  = 3'd1;
  localparam logic [2:0] ST_BAD_ADDR = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_TOO_MANY = 3'd4;

  localparam logic REG_LOWEST = 1'b0;
  localparam logic REG_LIMIT  = 1'b1;

  localparam logic [19:0] LOWEST_RST = 20'd0;
  localparam logic [20:0] LIMIT_RST  = 21'd57344;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] page_address;
    logic [31:0] random_value;
    logic [6:0]  dump_count;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] frame_address;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic capture;
    logic decode_err;
    logic walk_clr;
    logic push;
    logic res_ok;
    logic rec_rd;
    logic rec_chk;
    logic rec_done;
    logic div_start;
    logic div_step;
    logic fl_get;
    logic fl_pick;
    logic fl_rd;
    logic fl_mv;
    logic alloc_done;
    logic dump_rd;
    logic dump_out;
    logic dump_next;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       dec_err;
    logic       rec_empty;
    logic       rec_end;
    logic       div_last;
    logic       fl_end;
    logic       dump_last;
    logic       out_free;
  } sts_t;

endpackage
`default_nettype wire

@@ design/rppa_dp.sv @@
`default_nettype none
module rppa_dp #(
  parameter int MAX_FREE_PAGES = 1024,
  parameter int RECORD_SLOTS   = 512
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire rppa_pkg::req_t req,
  input  wire logic          cfg_we,
  input  wire logic          cfg_index,
  input  wire logic [20:0]   cfg_data,
  input  wire rppa_pkg::cmd_t cmd,
  output rppa_pkg::sts_t     sts,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output rppa_pkg::rsp_t     rsp
);
  import rppa_pkg::*;

  localparam int FCW = $clog2(MAX_FREE_PAGES + 1);
  localparam int FIW = $clog2(MAX_FREE_PAGES);
  localparam int RCW = $clog2(RECORD_SLOTS + 1);
  localparam int RIW = $clog2(RECORD_SLOTS);

  req_t            req_q;
  logic [19:0]     lowest;
  logic [20:0]     limit;
  logic [FCW-1:0]  free_total;
  logic [RCW-1:0]  taken_total;
  logic [FCW-1:0]  fidx;
  logic [RCW-1:0]  ridx;
  logic [RCW-1:0]  widx;
  logic [RCW-1:0]  widx_next;
  logic [FCW-1:0]  rem;
  logic [31:0]     dq;
  logic [4:0]      dcnt;
  logic [PN_W-1:0] pick;
  logic [PN_W-1:0] frd;
  logic [PN_W-1:0] rrd;
  logic [2:0]      res_status;
  logic [31:0]     res_frame;

  logic [PN_W-1:0] free_mem [MAX_FREE_PAGES];
  logic [PN_W-1:0] rec_mem  [RECORD_SLOTS];

  logic [PN_W-1:0] pn;
  logic            addr_bad;
  logic            cnt_bad;
  logic [2:0]      dec_code;
  logic            dec_err;
  logic [FCW:0]    div_t;
  logic [FCW-1:0]  q;
  logic            rec_ne;

  assign pn       = req_q.page_address[31:PAGE_SHIFT];
  assign addr_bad = (req_q.page_address[PAGE_SHIFT-1:0] != '0) || (pn < lowest) ||
                    ({1'b0, pn} >= limit);
  assign cnt_bad  = (req_q.dump_count == 7'd0) || (req_q.dump_count > 7'(DUMP_MAX)) ||
                    (32'(req_q.dump_count) > 32'(taken_total));
  assign div_t    = {rem, dq[31]};
  assign q        = free_total - FCW'(1) - rem;
  assign rec_ne   = (rrd != pn);
  assign widx_next = rec_ne ? RCW'(widx + RCW'(1)) : widx;

  always_comb begin
    dec_err  = 1'b0;
    dec_code = ST_OK;
    case (req_q.kind)
      KIND_FREE: begin
        if (addr_bad) begin
          dec_err  = 1'b1;
          dec_code = ST_BAD_ADDR;
        end else if (free_total == FCW'(MAX_FREE_PAGES)) begin
          dec_err  = 1'b1;
          dec_code = ST_FULL;
        end
      end
      KIND_ALLOC: begin
        if (free_total == '0) begin
          dec_err  = 1'b1;
          dec_code = ST_NO_FREE;
        end else if (taken_total == RCW'(RECORD_SLOTS)) begin
          dec_err  = 1'b1;
          dec_code = ST_FULL;
        end
      end
      KIND_DUMP: begin
        if (cnt_bad) begin
          dec_err  = 1'b1;
          dec_code = ST_TOO_MANY;
        end
      end
      default: begin
        dec_err  = 1'b1;
        dec_code = ST_BAD_ADDR;
      end
    endcase
  end

  always_comb begin
    sts.kind      = req_q.kind;
    sts.dec_err   = dec_err;
    sts.rec_empty = (taken_total == '0);
    sts.rec_end   = (RCW'(ridx + RCW'(1)) == taken_total);
    sts.div_last  = (dcnt == 5'd31);
    sts.fl_end    = (fidx == free_total);
    sts.dump_last = ((32'(ridx) + 32'd1) == 32'(req_q.dump_count));
    sts.out_free  = !rsp_valid || !rsp_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lowest      <= LOWEST_RST;
      limit       <= LIMIT_RST;
      free_total  <= '0;
      taken_total <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_LOWEST) begin
          lowest <= cfg_data[19:0];
        end else begin
          limit <= cfg_data;
        end
      end
      if (cmd.push) begin
        free_total <= FCW'(free_total + FCW'(1));
      end else if (cmd.alloc_done) begin
        free_total <= FCW'(free_total - FCW'(1));
      end
      if (cmd.rec_done) begin
        taken_total <= widx_next;
      end else if (cmd.alloc_done) begin
        taken_total <= RCW'(taken_total + RCW'(1));
      end
      if (cmd.emit || cmd.dump_out) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q <= req;
    end
    if (cmd.walk_clr) begin
      ridx <= '0;
      widx <= '0;
    end else if (cmd.rec_chk) begin
      ridx <= RCW'(ridx + RCW'(1));
      widx <= widx_next;
    end else if (cmd.dump_next) begin
      ridx <= RCW'(ridx + RCW'(1));
    end
    if (cmd.div_start) begin
      rem  <= '0;
      dq   <= req_q.random_value;
      dcnt <= '0;
    end else if (cmd.div_step) begin
      rem  <= (div_t >= {1'b0, free_total}) ? FCW'(div_t - {1'b0, free_total})
                                            : div_t[FCW-1:0];
      dq   <= {dq[30:0], 1'b0};
      dcnt <= 5'(dcnt + 5'd1);
    end
    if (cmd.fl_get) begin
      fidx <= FCW'(q + FCW'(1));
    end else if (cmd.fl_mv) begin
      fidx <= FCW'(fidx + FCW'(1));
    end
    if (cmd.fl_pick) begin
      pick <= frd;
    end
    if (cmd.decode_err) begin
      res_status <= dec_code;
      res_frame  <= '0;
    end else if (cmd.res_ok || cmd.rec_done) begin
      res_status <= ST_OK;
      res_frame  <= '0;
    end else if (cmd.alloc_done) begin
      res_status <= ST_OK;
      res_frame  <= {pick, {PAGE_SHIFT{1'b0}}};
    end
    if (cmd.emit) begin
      rsp.status        <= res_status;
      rsp.frame_address <= res_frame;
      rsp.last          <= 1'b1;
    end else if (cmd.dump_out) begin
      rsp.status        <= ST_OK;
      rsp.frame_address <= {rrd, {PAGE_SHIFT{1'b0}}};
      rsp.last          <= sts.dump_last;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      free_mem[free_total[FIW-1:0]] <= pn;
    end else if (cmd.fl_mv) begin
      free_mem[FIW'(fidx - FCW'(1))] <= frd;
    end
    if (cmd.fl_get) begin
      frd <= free_mem[q[FIW-1:0]];
    end else if (cmd.fl_rd) begin
      frd <= free_mem[fidx[FIW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rec_chk && rec_ne) begin
      rec_mem[widx[RIW-1:0]] <= rrd;
    end else if (cmd.alloc_done) begin
      rec_mem[taken_total[RIW-1:0]] <= pick;
    end
    if (cmd.rec_rd) begin
      rrd <= rec_mem[ridx[RIW-1:0]];
    end else if (cmd.dump_rd) begin
      rrd <= rec_mem[RIW'(taken_total - RCW'(1) - ridx)];
    end
  end

`ifndef ASSERT_OFF
  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    free_total <= FCW'(MAX_FREE_PAGES))
    else $error("free count above capacity");
  a_rec_bound: assert property (@(posedge clk) disable iff (rst)
    taken_total <= RCW'(RECORD_SLOTS))
    else $error("record count above capacity");
  a_nonlast_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.last |-> rsp.status == ST_OK)
    else $error("non-final transaction with error status");
  a_alloc_count: assert property (@(posedge clk) disable iff (rst)
    cmd.alloc_done |=> taken_total == RCW'($past(taken_total) + RCW'(1)))
    else $error("record count not advanced on alloc");
`endif

endmodule
`default_nettype wire

@@ design/rppa_ctrl.sv @@
`default_nettype none
module rppa_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_stall,
  input  wire rppa_pkg::sts_t sts,
  output rppa_pkg::cmd_t      cmd
);
  import rppa_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE     = 12'b000000000001,
    S_DECODE   = 12'b000000000010,
    S_EMIT     = 12'b000000000100,
    S_REC_RD   = 12'b000000001000,
    S_REC_CHK  = 12'b000000010000,
    S_DIV      = 12'b000000100000,
    S_FL_GET   = 12'b000001000000,
    S_FL_PICK  = 12'b000010000000,
    S_FL_RD    = 12'b000100000000,
    S_FL_MV    = 12'b001000000000,
    S_DUMP_RD  = 12'b010000000000,
    S_DUMP_OUT = 12'b100000000000
  } state_t;

  state_t state;
  state_t state_next;

  assign req_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.walk_clr = 1'b1;
        if (sts.dec_err) begin
          cmd.decode_err = 1'b1;
          state_next     = S_EMIT;
        end else begin
          case (sts.kind)
            KIND_FREE: begin
              cmd.push = 1'b1;
              if (sts.rec_empty) begin
                cmd.res_ok = 1'b1;
                state_next = S_EMIT;
              end else begin
                state_next = S_REC_RD;
              end
            end
            KIND_ALLOC: begin
              cmd.div_start = 1'b1;
              state_next    = S_DIV;
            end
            default: begin
              state_next = S_DUMP_RD;
            end
          endcase
        end
      end
      S_REC_RD: begin
        cmd.rec_rd = 1'b1;
        state_next = S_REC_CHK;
      end
      S_REC_CHK: begin
        cmd.rec_chk = 1'b1;
        if (sts.rec_end) begin
          cmd.rec_done = 1'b1;
          state_next   = S_EMIT;
        end else begin
          state_next = S_REC_RD;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = S_FL_GET;
        end
      end
      S_FL_GET: begin
        cmd.fl_get = 1'b1;
        state_next = S_FL_PICK;
      end
      S_FL_PICK: begin
        cmd.fl_pick = 1'b1;
        state_next  = S_FL_RD;
      end
      S_FL_RD: begin
        if (sts.fl_end) begin
          cmd.alloc_done = 1'b1;
          state_next     = S_EMIT;
        end else begin
          cmd.fl_rd  = 1'b1;
          state_next = S_FL_MV;
        end
      end
      S_FL_MV: begin
        cmd.fl_mv  = 1'b1;
        state_next = S_FL_RD;
      end
      S_DUMP_RD: begin
        cmd.dump_rd = 1'b1;
        state_next  = S_DUMP_OUT;
      end
      S_DUMP_OUT: begin
        if (sts.out_free) begin
          cmd.dump_out = 1'b1;
          if (sts.dump_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.dump_next = 1'b1;
            state_next    = S_DUMP_RD;
          end
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef ASSERT_OFF
  a_capture_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> state == S_DECODE)
    else $error("capture did not start decode");
  a_out_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.emit && cmd.dump_out))
    else $error("two result loads in one cycle");
  a_div_len: assert property (@(posedge clk) disable iff (rst)
    state == S_FL_GET |-> $past(state) == S_DIV)
    else $error("pick without division");
`endif

endmodule
`default_nettype wire

@@ design/random_pick_page_allocator_top.sv @@
// Free: appends the page to the free list, then walks the record list removing entries that match it.
// Alloc: a 32-step remainder unit and a pick, then each
//   free-list entry past the picked position is shifted down.
// Dump: reads then outputs each reported frame, newest first. Errors: decode then emit. One transaction at a time.
// Reset clears counts, configuration and control; list memories are not cleared.
`default_nettype none
module random_pick_page_allocator_top #(
  parameter int MAX_FREE_PAGES = 1024,
  parameter int RECORD_SLOTS   = 512
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_stall,
  input  wire rppa_pkg::req_t req,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  output rppa_pkg::rsp_t      rsp,
  input  wire logic           cfg_we,
  input  wire logic           cfg_index,
  input  wire logic [20:0]    cfg_data
);
  import rppa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rppa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  rppa_dp #(
    .MAX_FREE_PAGES (MAX_FREE_PAGES),
    .RECORD_SLOTS   (RECORD_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rppa_pkg::*;

  localparam int FREE_SLOTS = 1024;
  localparam int REC_SLOTS  = 512;
  localparam int LIMIT      = 20000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;
  logic cfg_we = 1'b0;
  logic cfg_index = REG_LOWEST;
  logic [20:0] cfg_data = '0;

  random_pick_page_allocator_top dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  logic [19:0] free_pg [FREE_SLOTS];
  int free_cnt = 0;
  logic [19:0] taken_pg [REC_SLOTS];
  int taken_cnt = 0;
  logic [19:0] low_pg = LOWEST_RST;
  logic [20:0] lim_pg = LIMIT_RST;
  rsp_t expected_rsp_q[$];
  int errors = 0;
  int cycles = 0;
  int burst_left = 0;

  function automatic rsp_t mk_rsp(logic [2:0] st, logic [31:0] fa, logic lst);
    rsp_t x;
    x.status = st;
    x.frame_address = fa;
    x.last = lst;
    return x;
  endfunction

  task automatic model_page_op(req_t r);
    logic [19:0] pn;
    int pos;
    int w;
    int unsigned rv;
    case (r.kind)
      KIND_FREE: begin
        pn = r.page_address[31:12];
        if (r.page_address[11:0] != 12'h0 || pn < low_pg || {1'b0, pn} >= lim_pg) begin
          expected_rsp_q.push_back(mk_rsp(ST_BAD_ADDR, 32'h0, 1'b1));
        end else if (free_cnt >= FREE_SLOTS) begin
          expected_rsp_q.push_back(mk_rsp(ST_FULL, 32'h0, 1'b1));
        end else begin
          for (int i = free_cnt; i > 0; i--) free_pg[i] = free_pg[i-1];
          free_pg[0] = pn;
          free_cnt++;
          w = 0;
          for (int i = 0; i < taken_cnt; i++) begin
            if (taken_pg[i] != pn) begin
              taken_pg[w] = taken_pg[i];
              w++;
            end
          end
          taken_cnt = w;
          expected_rsp_q.push_back(mk_rsp(ST_OK, 32'h0, 1'b1));
        end
      end
      KIND_ALLOC: begin
        if (free_cnt == 0) begin
          expected_rsp_q.push_back(mk_rsp(ST_NO_FREE, 32'h0, 1'b1));
        end else if (taken_cnt >= REC_SLOTS) begin
          expected_rsp_q.push_back(mk_rsp(ST_FULL, 32'h0, 1'b1));
        end else begin
          rv = r.random_value;
          pos = int'(rv % free_cnt);
          pn = free_pg[pos];
          for (int i = pos; i + 1 < free_cnt; i++) free_pg[i] = free_pg[i+1];
          free_cnt--;
          taken_pg[taken_cnt] = pn;
          taken_cnt++;
          expected_rsp_q.push_back(mk_rsp(ST_OK, {pn, 12'h0}, 1'b1));
        end
      end
      KIND_DUMP: begin
        if (r.dump_count == 0 || r.dump_count > DUMP_MAX || r.dump_count > taken_cnt) begin
          expected_rsp_q.push_back(mk_rsp(ST_TOO_MANY, 32'h0, 1'b1));
        end else begin
          for (int k = 0; k < r.dump_count; k++)
            expected_rsp_q.push_back(mk_rsp(ST_OK, {taken_pg[taken_cnt-1-k], 12'h0},
                                            k + 1 == r.dump_count));
        end
      end
      default: expected_rsp_q.push_back(mk_rsp(ST_BAD_ADDR, 32'h0, 1'b1));
    endcase
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAIL random_pick_page_allocator_top");
      $finish;
    end
  end

  int stall_mode = 0;
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(5, 80);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: rsp_stall <= 1'b0;
      1: rsp_stall <= ($urandom_range(0, 1) == 0);
      2: rsp_stall <= ($urandom_range(0, 3) != 0);
      default: rsp_stall <= (stall_left % 8) < 3;
    endcase
  end

  always @(negedge clk) begin
    rsp_t e;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_rsp_q.size() == 0) begin
        $error("unexpected transaction: status %0d frame_address %h last %0d",
               rsp.status, rsp.frame_address, rsp.last);
        errors++;
      end else begin
        e = expected_rsp_q.pop_front();
        if (rsp.status !== e.status) begin
          $error("status: expected %0d actual %0d", e.status, rsp.status);
          errors++;
        end
        if (rsp.frame_address !== e.frame_address) begin
          $error("frame_address: expected %h actual %h", e.frame_address, rsp.frame_address);
          errors++;
        end
        if (rsp.last !== e.last) begin
          $error("last: expected %0d actual %0d", e.last, rsp.last);
          errors++;
        end
      end
    end
  end

  task automatic send_req(req_t r, bit typed, logic [2:0] st, logic [31:0] fa);
    bit ok;
    req <= r;
    req_valid <= 1'b1;
    do begin
      @(negedge clk);
      ok = !req_stall;
      @(posedge clk);
    end while (!ok);
    model_page_op(r);
    if (typed) expected_rsp_q[$] = mk_rsp(st, fa, 1'b1);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 10);
    end
  endtask

  task automatic issue(req_t r);
    send_req(r, 1'b0, ST_OK, 32'h0);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [20:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_LOWEST) low_pg = val[19:0];
    else lim_pg = val;
  endtask

  task automatic set_bounds(logic [19:0] lo, logic [20:0] hi);
    drain();
    write_cfg(REG_LOWEST, {1'b0, lo});
    write_cfg(REG_LIMIT, hi);
  endtask

  function automatic req_t mk_req(logic [1:0] k, logic [31:0] a, logic [31:0] rv,
                                  logic [6:0] c);
    req_t r;
    r.kind = k;
    r.page_address = a;
    r.random_value = rv;
    r.dump_count = c;
    return r;
  endfunction

  function automatic req_t rand_req();
    req_t r;
    int sel;
    int span;
    r = mk_req(KIND_FREE, $urandom, $urandom, 7'($urandom));
    sel = $urandom_range(0, 99);
    if (sel < 40) begin
      r.kind = KIND_FREE;
      span = int'(lim_pg) - int'(low_pg);
      case ($urandom_range(0, 5))
        0, 1, 2: if (span > 0)
          r.page_address = {20'(low_pg + $urandom_range(0, span - 1)), 12'h0};
        3, 4: if (taken_cnt > 0)
          r.page_address = {taken_pg[$urandom_range(0, taken_cnt - 1)], 12'h0};
        default: ;
      endcase
    end else if (sel < 75) begin
      r.kind = KIND_ALLOC;
    end else if (sel < 95) begin
      r.kind = KIND_DUMP;
      if ($urandom_range(0, 4) != 0 && taken_cnt > 0)
        r.dump_count = 7'($urandom_range(1, taken_cnt < 8 ? taken_cnt : 8));
    end else begin
      r.kind = 2'd3;
    end
    return r;
  endfunction

  typedef struct {
    req_t r;
    bit typed;
    logic [2:0] st;
    logic [31:0] fa;
  } row_t;

  row_t rows[$];

  task automatic add_row(logic [1:0] k, logic [31:0] a, logic [31:0] rv, logic [6:0] c,
                         bit typed, logic [2:0] st, logic [31:0] fa);
    row_t x;
    x.r = mk_req(k, a, rv, c);
    x.typed = typed;
    x.st = st;
    x.fa = fa;
    rows.push_back(x);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    add_row(KIND_ALLOC, 32'h0, 32'd5, 7'd0, 1, ST_NO_FREE, 32'h0);
    add_row(KIND_DUMP, 32'h0, 32'h0, 7'd1, 1, ST_TOO_MANY, 32'h0);
    add_row(2'd3, 32'hFFFFFFFF, 32'hFFFFFFFF, 7'h7F, 1, ST_BAD_ADDR, 32'h0);
    add_row(KIND_FREE, 32'h00001001, 32'h0, 7'd0, 1, ST_BAD_ADDR, 32'h0);
    add_row(KIND_FREE, 32'hFFFFF000, 32'h0, 7'd0, 1, ST_BAD_ADDR, 32'h0);
    add_row(KIND_FREE, 32'h0E000000, 32'h0, 7'd0, 1, ST_BAD_ADDR, 32'h0);
    add_row(KIND_FREE, 32'h00000000, 32'h0, 7'd0, 1, ST_OK, 32'h0);
    add_row(KIND_FREE, 32'h0DFFF000, 32'h0, 7'd0, 1, ST_OK, 32'h0);
    add_row(KIND_FREE, 32'h00005000, 32'h0, 7'd0, 1, ST_OK, 32'h0);
    add_row(KIND_FREE, 32'h00005000, 32'h0, 7'd0, 1, ST_OK, 32'h0);
    add_row(KIND_DUMP, 32'h0, 32'h0, 7'd0, 1, ST_TOO_MANY, 32'h0);
    add_row(KIND_DUMP, 32'h0, 32'h0, 7'd64, 1, ST_TOO_MANY, 32'h0);
    add_row(KIND_ALLOC, 32'h0, 32'h0, 7'd0, 1, ST_OK, 32'h00005000);
    add_row(KIND_ALLOC, 32'h0, 32'hFFFFFFFF, 7'd0, 0, ST_OK, 32'h0);
    add_row(KIND_ALLOC, 32'h0, 32'd7, 7'd0, 0, ST_OK, 32'h0);
    add_row(KIND_DUMP, 32'h0, 32'h0, 7'd3, 0, ST_OK, 32'h0);
    add_row(KIND_FREE, 32'h00005000, 32'h0, 7'd0, 1, ST_OK, 32'h0);
    add_row(KIND_DUMP, 32'h0, 32'h0, 7'd2, 0, ST_OK, 32'h0);
    add_row(KIND_DUMP, 32'h0, 32'h0, 7'd127, 1, ST_TOO_MANY, 32'h0);
    add_row(KIND_ALLOC, 32'h0, 32'd1, 7'd0, 0, ST_OK, 32'h0);
    add_row(KIND_ALLOC, 32'h0, 32'd2, 7'd0, 0, ST_OK, 32'h0);
    add_row(KIND_ALLOC, 32'h0, 32'd3, 7'd0, 0, ST_OK, 32'h0);
    add_row(KIND_DUMP, 32'h0, 32'h0, 7'd1, 0, ST_OK, 32'h0);
    foreach (rows[i]) send_req(rows[i].r, rows[i].typed, rows[i].st, rows[i].fa);

    set_bounds(20'd0, 21'd0);
    repeat (5) issue(mk_req(KIND_FREE, {20'($urandom), 12'h0}, 32'h0, 7'd0));
    set_bounds(20'hFFFFF, 21'h100000);
    issue(mk_req(KIND_FREE, 32'hFFFFF000, 32'h0, 7'd0));
    issue(mk_req(KIND_FREE, 32'hFFFFE000, 32'h0, 7'd0));

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: set_bounds(20'd16, 21'd4096);
        1: set_bounds(20'd0, 21'h100000);
        2: set_bounds(20'($urandom_range(0, 1000)), 21'($urandom_range(1000, 1100)));
        default: set_bounds(20'd0, 21'd64);
      endcase
      for (int i = 0; i < 75; i++) begin
        if (p == 1 && i == 40) drain();
        issue(rand_req());
      end
    end

    set_bounds(20'd0, 21'h100000);
    while (free_cnt < FREE_SLOTS)
      issue(mk_req(KIND_FREE, {20'($urandom), 12'h0}, 32'h0, 7'd0));
    issue(mk_req(KIND_FREE, 32'h00001000, 32'h0, 7'd0));
    while (taken_cnt < REC_SLOTS)
      issue(mk_req(KIND_ALLOC, 32'h0, 32'(free_cnt - 1 - $urandom_range(0, 3)), 7'd0));
    issue(mk_req(KIND_ALLOC, 32'h0, $urandom, 7'd0));
    issue(mk_req(KIND_DUMP, 32'h0, 32'h0, 7'd64));
    issue(mk_req(KIND_DUMP, 32'h0, 32'h0, 7'd65));
    issue(mk_req(KIND_FREE, {taken_pg[0], 12'h0}, 32'h0, 7'd0));
    issue(mk_req(KIND_FREE, {taken_pg[REC_SLOTS - 2], 12'h0}, 32'h0, 7'd0));
    issue(mk_req(KIND_DUMP, 32'h0, 32'h0, 7'd5));

    drain();
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("PASS random_pick_page_allocator_top");
    end else begin
      $display("FAIL random_pick_page_allocator_top");
    end
    $finish;
  end

endmodule
`default_nettype wire
